// File: hdl/cfar_ring_detector_2d_assert.svh
// ----------------------------------------------------------------------------
// CFAR ring detector assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CFAR_RING_DETECTOR_2D_ASSERT_SVH
`define CFAR_RING_DETECTOR_2D_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFAR2D_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFAR2D_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cfar2d_pkg.sv
// ----------------------------------------------------------------------------
// CFAR ring detector package
// Item types of both channels and configuration register codes.
// ----------------------------------------------------------------------------
package cfar2d_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    localparam logic [3:0]  RST_RING_RADIUS  = 4'd3;
    localparam logic [2:0]  RST_GUARD_RADIUS = 3'd1;
    localparam logic [11:0] RST_SIGMA_GAIN   = 12'd768;
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd512;

    localparam int MAX_HEIGHT = 1024;

    typedef struct packed {
        logic [15:0] sample;
        logic        frame_start;
    } t_pix_item;

    typedef struct packed {
        logic [9:0]  center_row;
        logic [9:0]  center_col;
        logic        is_target;
        logic [19:0] background_mean;
        logic [18:0] background_sigma;
        logic        frame_done;
    } t_res_item;

endpackage

// File: hdl/cfar2d_stream_if.sv
// ----------------------------------------------------------------------------
// CFAR ring detector stream interface
// Valid/ready channel that moves one item per handshake.
// ----------------------------------------------------------------------------
interface cfar2d_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/cfar2d_ram.sv
// ----------------------------------------------------------------------------
// CFAR ring detector RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cfar2d_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/cfar2d_div.sv
// ----------------------------------------------------------------------------
// CFAR ring detector divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfar2d_div #(
    parameter int DW = 8,
    parameter int VW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_q;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      c_shift;
    logic [VW:0]      c_diff;
    logic             c_ge;

    // Remainder stays below the divisor, so the shifted value is below twice it.
    assign c_shift = {r_rem, r_q[DW-1]};
    assign c_diff  = c_shift - {1'b0, r_den};
    assign c_ge    = c_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], c_ge};
            r_rem <= c_ge ? c_diff[VW-1:0] : c_shift[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// File: hdl/cfar2d_sqrt.sv
// ----------------------------------------------------------------------------
// CFAR ring detector square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cfar2d_sqrt #(
    parameter int W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_value,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);
    localparam int CNT_W = $clog2(W / 2 + 1);

    logic [W-1:0]     r_x;
    logic [W-1:0]     r_res;
    logic [W-1:0]     r_probe;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W:0]       c_trial;
    logic             c_ge;

    assign c_trial = {1'b0, r_res} + {1'b0, r_probe};
    assign c_ge    = {1'b0, r_x} >= c_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W / 2);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x     <= i_value;
            r_res   <= '0;
            r_probe <= W'(1) << (W - 2);
        end else if (r_busy) begin
            if (c_ge) begin
                r_x   <= r_x - c_trial[W-1:0];
                r_res <= (r_res >> 1) + r_probe;
            end else begin
                r_res <= r_res >> 1;
            end
            r_probe <= r_probe >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[W/2-1:0];
endmodule

// File: hdl/cfar_ring_detector_2d.sv
// ----------------------------------------------------------------------------
// CFAR ring detector, two-dimensional
// Mean and sigma cell-averaging CFAR over a square reference ring.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Payload     Handshake
//   i_pix     in   t_pix_item  valid/ready, taken when both are high
//   o_res     out  t_res_item  valid/ready, held until taken
//   i_cfg_*   in   idx, data   write enable only, no wait
//
// A border pixel leaves the engine idle. An interior pixel starts a window
// sweep that reads the line store once per cycle; then the shared divider,
// whose quotient is 58 bits wide at default parameters, runs twice and the
// square root once. Reset is synchronous and leaves the line store
// unwritten. A stalled output keeps the engine in its last state but the
// next pixel is still taken once the result sits in the output register.
//
`include "cfar_ring_detector_2d_assert.svh"

module cfar_ring_detector_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cfar2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cfar2d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    cfar2d_stream_if.sink                      i_pix,
    cfar2d_stream_if.source                    o_res
);
    import cfar2d_pkg::*;

    // Window and arithmetic widths all follow from the parameters.
    localparam int WIN       = 2 * MAX_RADIUS + 1;
    localparam int STORE_ROWS = WIN;
    localparam int N_BITS    = $clog2(WIN * WIN + 1);
    localparam int SUM_BITS  = PIXEL_BITS + N_BITS;
    localparam int SQ_BITS   = 2 * PIXEL_BITS + N_BITS;
    localparam int D_BITS    = SQ_BITS + N_BITS;
    localparam int DIV_DW    = D_BITS + 8;
    localparam int DIV_VW    = 2 * N_BITS;
    localparam int ROOT_IN   = DIV_DW + (DIV_DW % 2);
    localparam int ROOT_W    = ROOT_IN / 2;
    localparam int MEAN_BITS = PIXEL_BITS + 4;
    localparam int SIG_BITS  = PIXEL_BITS + 4;
    localparam int KS_W      = 12 + SIG_BITS;
    localparam int CMP_W     = KS_W + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WC_W      = COL_W + 1;
    localparam int SLOT_W    = $clog2(STORE_ROWS);
    localparam int ADDR_W    = $clog2(STORE_ROWS * MAX_WIDTH);
    localparam int R_W       = $clog2(MAX_RADIUS + 1);
    localparam int I_W       = $clog2(WIN);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SWEEP = 10'b0000000010,
        S_DRAIN = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_DIFF  = 10'b0000010000,
        S_DIVM  = 10'b0000100000,
        S_DIVV  = 10'b0001000000,
        S_SQRT  = 10'b0010000000,
        S_THR   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (32'(s) == STORE_ROWS - 1) ? '0 : s + 1'b1;
    endfunction

    // Configuration registers.
    logic [3:0]  r_ring_radius;
    logic [2:0]  r_guard_radius;
    logic [11:0] r_sigma_gain;
    logic [10:0] r_frame_width;
    logic [10:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_radius  <= RST_RING_RADIUS;
            r_guard_radius <= RST_GUARD_RADIUS;
            r_sigma_gain   <= RST_SIGMA_GAIN;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RING_RADIUS:  r_ring_radius  <= i_cfg_data[3:0];
                CFG_GUARD_RADIUS: r_guard_radius <= i_cfg_data[2:0];
                CFG_SIGMA_GAIN:   r_sigma_gain   <= i_cfg_data;
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Effective settings: radius, guard and frame size clamped to what the
    // hardware can hold; the guard always stays inside the ring.
    logic [R_W-1:0]  c_rad;
    logic [R_W-1:0]  c_grd;
    logic [R_W:0]    c_two_rad;
    logic [WC_W-1:0] c_w;
    logic [10:0]     c_h;

    always_comb begin
        if (r_ring_radius == 4'd0) begin
            c_rad = R_W'(1);
        end else if (32'(r_ring_radius) > MAX_RADIUS) begin
            c_rad = R_W'(MAX_RADIUS);
        end else begin
            c_rad = R_W'(r_ring_radius);
        end
        if (32'(r_guard_radius) < 32'(c_rad)) begin
            c_grd = R_W'(r_guard_radius);
        end else begin
            c_grd = c_rad - R_W'(1);
        end
        c_two_rad = {c_rad, 1'b0};
        if (r_frame_width < 11'd3) begin
            c_w = WC_W'(3);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            c_w = WC_W'(MAX_WIDTH);
        end else begin
            c_w = WC_W'(r_frame_width);
        end
        if (r_frame_height < 11'd3) begin
            c_h = 11'd3;
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            c_h = 11'(MAX_HEIGHT);
        end else begin
            c_h = r_frame_height;
        end
    end

    // Raster position. r_slot is the line store row that holds the current
    // image row, kept as a running counter modulo the number of store rows.
    t_state             r_state;
    t_state             n_state;
    logic [9:0]         r_row_pos;
    logic [COL_W-1:0]   r_col_pos;
    logic [SLOT_W-1:0]  r_slot;
    logic [10:0]        c_row;
    logic [10:0]        c_row1;
    logic [WC_W-1:0]    c_col;
    logic [WC_W-1:0]    c_col1;
    logic [SLOT_W-1:0]  c_slot;
    logic [SLOT_W-1:0]  c_slot1;
    logic [SLOT_W-1:0]  c_slot0;
    logic               c_acc;
    logic               c_interior;
    logic               c_last_px;

    assign c_acc = i_pix.valid && i_pix.ready;

    always_comb begin
        c_row  = 11'(r_row_pos);
        c_col  = WC_W'(r_col_pos);
        c_slot = r_slot;
        if (i_pix.payload.frame_start) begin
            c_row  = '0;
            c_col  = '0;
            c_slot = '0;
        end else begin
            // A frame that shrank since the last pixel wraps before placement.
            if (c_col >= c_w) begin
                c_col  = '0;
                c_row  = c_row + 11'd1;
                c_slot = slot_inc(c_slot);
            end
            if (c_row >= c_h) begin
                c_row  = '0;
                c_slot = '0;
            end
        end
        c_col1  = c_col + WC_W'(1);
        c_row1  = c_row;
        c_slot1 = c_slot;
        if (c_col1 >= c_w) begin
            c_col1  = '0;
            c_row1  = c_row + 11'd1;
            c_slot1 = slot_inc(c_slot);
            if (c_row1 >= c_h) begin
                c_row1  = '0;
                c_slot1 = '0;
            end
        end
        c_interior = (32'(c_row) >= 32'(c_two_rad)) && (32'(c_col) >= 32'(c_two_rad));
        c_last_px  = (c_row == c_h - 11'd1) && (c_col == c_w - WC_W'(1));
        if (32'(c_slot) >= 32'(c_two_rad)) begin
            c_slot0 = SLOT_W'(32'(c_slot) - 32'(c_two_rad));
        end else begin
            c_slot0 = SLOT_W'(32'(c_slot) + STORE_ROWS - 32'(c_two_rad));
        end
    end

    // Per-item registers of the window sweep.
    logic [PIXEL_BITS-1:0] r_px;
    logic [9:0]            r_crow;
    logic [9:0]            r_ccol;
    logic                  r_last_px;
    logic [I_W-1:0]        r_rad;
    logic [I_W-1:0]        r_grd;
    logic [I_W-1:0]        r_two_rad;
    logic [COL_W-1:0]      r_col0;
    logic [SLOT_W-1:0]     r_rs;
    logic [COL_W-1:0]      r_cc;
    logic [I_W-1:0]        r_i;
    logic [I_W-1:0]        r_j;
    logic [I_W-1:0]        c_di;
    logic [I_W-1:0]        c_dj;
    logic                  c_guard;
    logic                  c_last_i;
    logic                  c_last_j;

    always_comb begin
        c_di     = (r_rad < r_i) ? r_i - r_rad : r_rad - r_i;
        c_dj     = (r_rad < r_j) ? r_j - r_rad : r_rad - r_j;
        c_guard  = (c_di <= r_grd) && (c_dj <= r_grd);
        c_last_i = r_i == r_two_rad;
        c_last_j = r_j == r_two_rad;
    end

    // Line store: the accepted pixel is written in the cycle it is taken, and
    // the sweep that follows reads the whole window, that pixel included.
    logic [ADDR_W-1:0]     c_addr;
    logic [PIXEL_BITS-1:0] c_px;
    logic [PIXEL_BITS-1:0] w_rdata;

    assign c_px = i_pix.payload.sample[PIXEL_BITS-1:0];

    always_comb begin
        if (r_state == S_IDLE) begin
            c_addr = ADDR_W'(32'(c_slot) * MAX_WIDTH + 32'(c_col));
        end else begin
            c_addr = ADDR_W'(32'(r_rs) * MAX_WIDTH + 32'(r_cc));
        end
    end

    cfar2d_ram #(
        .DATA_W (PIXEL_BITS),
        .DEPTH  (STORE_ROWS * MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (c_acc),
        .i_addr  (c_addr),
        .i_wdata (c_px),
        .o_rdata (w_rdata)
    );

    // Ring statistics and the arithmetic that follows.
    logic                        r_rd_use;
    logic [SUM_BITS-1:0]         r_sum;
    logic [SQ_BITS-1:0]          r_sq;
    logic [N_BITS-1:0]           r_n;
    logic [D_BITS-1:0]           r_nsq;
    logic [2*SUM_BITS-1:0]       r_sum2;
    logic [DIV_VW-1:0]           r_n2;
    logic [D_BITS-1:0]           r_d;
    logic [MEAN_BITS-1:0]        r_mean;
    logic [SIG_BITS-1:0]         r_sigma;
    logic [KS_W-1:0]             r_ksig;
    logic [2*PIXEL_BITS-1:0]     c_sqr;
    logic                        c_div_start;
    logic [DIV_DW-1:0]           c_div_num;
    logic [DIV_VW-1:0]           c_div_den;
    logic                        w_div_done;
    logic [DIV_DW-1:0]           w_quot;
    logic                        c_sq_start;
    logic [ROOT_IN-1:0]          c_sq_in;
    logic                        w_sq_done;
    logic [ROOT_W-1:0]           w_root;

    assign c_sqr = w_rdata * w_rdata;

    always_comb begin
        if (r_state == S_DIFF) begin
            c_div_num = DIV_DW'({r_sum, 4'b0});
            c_div_den = DIV_VW'(r_n);
        end else begin
            c_div_num = {r_d, 8'b0};
            c_div_den = r_n2;
        end
        c_div_start = (r_state == S_DIFF) || ((r_state == S_DIVM) && w_div_done);
        // Variance is floored at one least step.
        c_sq_in    = (w_quot == '0) ? ROOT_IN'(1) : ROOT_IN'(w_quot);
        c_sq_start = (r_state == S_DIVV) && w_div_done;
    end

    cfar2d_div #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_div_start),
        .i_dividend (c_div_num),
        .i_divisor  (c_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    cfar2d_sqrt #(
        .W (ROOT_IN)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_sq_start),
        .i_value (c_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Output register and threshold test: pixel > mean + k * sigma, all
    // aligned to 12 fraction bits.
    logic            r_out_v;
    t_res_item       r_out;
    logic            c_load;
    logic [CMP_W-1:0] c_lhs;
    logic [CMP_W-1:0] c_rhs;

    assign c_load = (r_state == S_OUT) && (!r_out_v || o_res.ready);
    assign c_lhs  = CMP_W'({r_px, 12'b0});
    assign c_rhs  = CMP_W'({r_mean, 8'b0}) + CMP_W'(r_ksig);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (c_acc && c_interior) n_state = S_SWEEP;
            S_SWEEP: if (c_last_i && c_last_j) n_state = S_DRAIN;
            S_DRAIN: n_state = S_MUL;
            S_MUL:   n_state = S_DIFF;
            S_DIFF:  n_state = S_DIVM;
            S_DIVM:  if (w_div_done) n_state = S_DIVV;
            S_DIVV:  if (w_div_done) n_state = S_SQRT;
            S_SQRT:  if (w_sq_done) n_state = S_THR;
            S_THR:   n_state = S_OUT;
            S_OUT:   if (c_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_pos <= '0;
            r_col_pos <= '0;
            r_slot    <= '0;
            r_rd_use  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_use <= (r_state == S_SWEEP) && !c_guard;
            if (c_acc) begin
                r_row_pos <= c_row1[9:0];
                r_col_pos <= c_col1[COL_W-1:0];
                r_slot    <= c_slot1;
            end
            if (c_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_acc) begin
            r_px      <= c_px;
            r_crow    <= 10'(32'(c_row) - 32'(c_rad));
            r_ccol    <= 10'(32'(c_col) - 32'(c_rad));
            r_last_px <= c_last_px;
            r_rad     <= I_W'(c_rad);
            r_grd     <= I_W'(c_grd);
            r_two_rad <= I_W'(c_two_rad);
            r_col0    <= COL_W'(32'(c_col) - 32'(c_two_rad));
            r_cc      <= COL_W'(32'(c_col) - 32'(c_two_rad));
            r_rs      <= c_slot0;
            r_i       <= '0;
            r_j       <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_n       <= '0;
        end else begin
            if (r_state == S_SWEEP) begin
                if (c_last_j) begin
                    r_j  <= '0;
                    r_cc <= r_col0;
                    r_i  <= r_i + 1'b1;
                    r_rs <= slot_inc(r_rs);
                end else begin
                    r_j  <= r_j + 1'b1;
                    r_cc <= r_cc + 1'b1;
                end
            end
            if (r_rd_use) begin
                r_sum <= r_sum + SUM_BITS'(w_rdata);
                r_sq  <= r_sq + SQ_BITS'(c_sqr);
                r_n   <= r_n + 1'b1;
            end
        end
        if (r_state == S_MUL) begin
            r_nsq  <= D_BITS'(r_n) * r_sq;
            r_sum2 <= r_sum * r_sum;
            r_n2   <= r_n * r_n;
        end
        if (r_state == S_DIFF) begin
            r_d <= r_nsq - D_BITS'(r_sum2);
        end
        if ((r_state == S_DIVM) && w_div_done) begin
            r_mean <= w_quot[MEAN_BITS-1:0];
        end
        if ((r_state == S_SQRT) && w_sq_done) begin
            r_sigma <= w_root[SIG_BITS-1:0];
        end
        if (r_state == S_THR) begin
            r_ksig <= r_sigma_gain * r_sigma;
        end
        if (c_load) begin
            r_out.center_row       <= r_crow;
            r_out.center_col       <= r_ccol;
            r_out.is_target        <= c_lhs > c_rhs;
            r_out.background_mean  <= 20'(r_mean);
            r_out.background_sigma <= 19'(r_sigma);
            r_out.frame_done       <= r_last_px;
        end
    end

    assign i_pix.ready   = r_state == S_IDLE;
    assign o_res.valid   = r_out_v;
    assign o_res.payload = r_out;

    `CFAR2D_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, w_div_done, (r_state == S_DIVM) || (r_state == S_DIVV), "divider finished outside a division step")
    `CFAR2D_ASSERT_IMP(a_sqrt_done_state, i_clk, i_rst_n, w_sq_done, r_state == S_SQRT, "square root finished outside its step")
    `CFAR2D_ASSERT_NXT(a_sweep_ends, i_clk, i_rst_n, (r_state == S_SWEEP) && c_last_i && c_last_j, r_state == S_DRAIN, "window sweep did not end after its last read")
    `CFAR2D_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT) && o_res.valid && !o_res.ready, r_state == S_OUT, "result overwrote a pending item")
endmodule

// File: verif/tb_cfar_ring_detector_2d.sv
// ----------------------------------------------------------------------------
// CFAR ring detector testbench
// Streams pixel frames through the detector under several register settings
// and compares every result with an in-bench predictor of the ring
// statistics, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cfar_ring_detector_2d;
    import cfar2d_pkg::*;

    localparam int STORE_ROWS  = 17;
    localparam int MAXW        = 1024;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE      = 700;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    cfar2d_stream_if #(.t_payload(t_pix_item)) pix_if ();
    cfar2d_stream_if #(.t_payload(t_res_item)) res_if ();

    cfar_ring_detector_2d dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the detector: registers, raster position and line store.
    logic [3:0]  sh_ring = RST_RING_RADIUS;
    logic [2:0]  sh_guard = RST_GUARD_RADIUS;
    logic [11:0] sh_gain = RST_SIGMA_GAIN;
    logic [10:0] sh_width = RST_FRAME_WIDTH;
    logic [10:0] sh_height = RST_FRAME_HEIGHT;
    int unsigned next_row = 0;
    int unsigned next_col = 0;
    logic [15:0] pixel_rows [STORE_ROWS*MAXW];

    t_pix_item pixel_q [$];
    t_res_item result_q [$];

    int  pix_taken = 0;
    int  res_taken = 0;
    int  fail_cnt = 0;
    int  quiet_cnt = 0;
    bit  pressure_done = 1'b0;
    int  hold_left = 0;

    initial begin
        foreach (pixel_rows[i]) pixel_rows[i] = '0;
        pix_if.valid = 1'b0;
        pix_if.payload = '0;
        res_if.ready = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Places one pixel in the shadow line store and, when the window around
    // the delayed centre lies inside the frame, queues the ring statistics.
    task automatic predict_ring(input t_pix_item it);
        int unsigned w, h, rad, grd, row, col, di, dj, rr;
        longint unsigned sum, sq, n, v, mean, var_q, sigma, lhs, rhs;
        t_res_item r;
        w = (sh_width < 3) ? 3 : (sh_width > MAXW ? MAXW : sh_width);
        h = (sh_height < 3) ? 3 : (sh_height > MAX_HEIGHT ? MAX_HEIGHT : sh_height);
        rad = (sh_ring < 1) ? 1 : (sh_ring > 8 ? 8 : sh_ring);
        grd = (sh_guard < rad) ? sh_guard : rad - 1;
        if (it.frame_start) begin
            row = 0;
            col = 0;
        end else begin
            row = next_row;
            col = next_col;
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (row >= h) row = 0;
        end
        pixel_rows[(row % STORE_ROWS) * MAXW + col] = it.sample;
        if (row >= 2 * rad && col >= 2 * rad) begin
            sum = 0;
            sq = 0;
            n = 0;
            for (int i = 0; i <= 2 * rad; i++) begin
                rr = row - 2 * rad + i;
                for (int j = 0; j <= 2 * rad; j++) begin
                    di = (i > rad) ? i - rad : rad - i;
                    dj = (j > rad) ? j - rad : rad - j;
                    if (!(di <= grd && dj <= grd)) begin
                        v = pixel_rows[(rr % STORE_ROWS) * MAXW + (col - 2 * rad + j)];
                        sum += v;
                        sq += v * v;
                        n++;
                    end
                end
            end
            mean = (sum * 16) / n;
            var_q = ((n * sq - sum * sum) * 256) / (n * n);
            // Flat rings are floored at one least step of variance.
            if (var_q < 1) var_q = 1;
            sigma = int_sqrt(var_q);
            lhs = longint'(it.sample) << 12;
            rhs = (mean << 8) + longint'(sh_gain) * sigma;
            r.center_row       = 10'(row - rad);
            r.center_col       = 10'(col - rad);
            r.is_target        = (lhs > rhs);
            r.background_mean  = mean[19:0];
            r.background_sigma = sigma[18:0];
            r.frame_done       = (row == h - 1 && col == w - 1);
            result_q.push_back(r);
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        next_row = row;
        next_col = col;
    endtask

    // Idling: first third the sender idles 18% and the receiver 60%, then the
    // other way round, then the last third runs with no idling at all.
    function automatic bit sender_idles();
        if (pix_taken < 650) return ($urandom_range(0, 99) < 18);
        if (pix_taken < 1300) return ($urandom_range(0, 99) < 60);
        return 1'b0;
    endfunction

    function automatic bit receiver_idles();
        if (pix_taken < 650) return ($urandom_range(0, 99) < 60);
        if (pix_taken < 1300) return ($urandom_range(0, 99) < 18);
        return 1'b0;
    endfunction

    // Pixel driver: an accepted item is predicted at the edge that takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                predict_ring(pix_if.payload);
                pix_taken++;
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (pixel_q.size() > 0 && !sender_idles()) begin
                    pix_if.payload <= pixel_q.pop_front();
                    pix_if.valid   <= 1'b1;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor, including one long hold-off that backs up the block
    // while plenty of pixels are still waiting to be sent.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                res_taken++;
                if (result_q.size() == 0) begin
                    $error("result with no expectation: row %0d col %0d",
                           res_if.payload.center_row, res_if.payload.center_col);
                    fail_cnt++;
                end else begin
                    t_res_item e;
                    t_res_item a;
                    e = result_q.pop_front();
                    a = res_if.payload;
                    if (a.center_row !== e.center_row) begin
                        $error("center_row: expected %0d, got %0d", e.center_row, a.center_row);
                        fail_cnt++;
                    end
                    if (a.center_col !== e.center_col) begin
                        $error("center_col: expected %0d, got %0d", e.center_col, a.center_col);
                        fail_cnt++;
                    end
                    if (a.is_target !== e.is_target) begin
                        $error("is_target: expected %0d, got %0d", e.is_target, a.is_target);
                        fail_cnt++;
                    end
                    if (a.background_mean !== e.background_mean) begin
                        $error("background_mean: expected %0d, got %0d",
                               e.background_mean, a.background_mean);
                        fail_cnt++;
                    end
                    if (a.background_sigma !== e.background_sigma) begin
                        $error("background_sigma: expected %0d, got %0d",
                               e.background_sigma, a.background_sigma);
                        fail_cnt++;
                    end
                    if (a.frame_done !== e.frame_done) begin
                        $error("frame_done: expected %0d, got %0d", e.frame_done, a.frame_done);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else if (!pressure_done && res_taken >= 15 && pixel_q.size() > 40) begin
                pressure_done <= 1'b1;
                hold_left     <= 3000;
                res_if.ready  <= 1'b0;
            end else begin
                res_if.ready <= !receiver_idles();
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Register write; the shadow follows the same masking as the block.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        case (idx)
            CFG_RING_RADIUS:  sh_ring   = d[3:0];
            CFG_GUARD_RADIUS: sh_guard  = d[2:0];
            CFG_SIGMA_GAIN:   sh_gain   = d[11:0];
            CFG_FRAME_WIDTH:  sh_width  = d[10:0];
            CFG_FRAME_HEIGHT: sh_height = d[10:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int r, input int g, input int k, input int w, input int h);
        cfg_write(CFG_RING_RADIUS, 12'(r));
        cfg_write(CFG_GUARD_RADIUS, 12'(g));
        cfg_write(CFG_SIGMA_GAIN, 12'(k));
        cfg_write(CFG_FRAME_WIDTH, 12'(w));
        cfg_write(CFG_FRAME_HEIGHT, 12'(h));
    endtask

    // Waits until every item is taken and every result has come, then lets
    // the engine settle since a trailing border pixel leaves no expectation.
    task automatic drain();
        while (pixel_q.size() > 0 || pix_if.valid || result_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [15:0] s, input bit fs);
        t_pix_item it;
        it.sample = s;
        it.frame_start = fs;
        pixel_q.push_back(it);
    endtask

    // Style 0 is full-range noise, 1 a quiet background with rare bright
    // spikes so that targets show up, 2 a flat image.
    function automatic logic [15:0] make_pixel(input int style, input int base);
        case (style)
            0: return 16'($urandom);
            1: begin
                if ($urandom_range(0, 19) == 0) return 16'($urandom_range(40000, 65535));
                return 16'(base + $urandom_range(0, 255));
            end
            default: return 16'(base);
        endcase
    endfunction

    initial begin
        int r, g, k, w, h, ew, eh, cnt, style, base, cut;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a few extreme pixels on the first row, no results.
        push_pixel(16'h0000, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'hAAAA, 1'b0);
        push_pixel(16'h5555, 1'b0);
        drain();

        // Radius zero acts as one, the guard saturates to zero and a width
        // and height below three are clamped. A flat frame hits the variance
        // floor; the second frame wraps in without a frame start; the third
        // has a lone bright centre, inside the guard, at zero gain.
        set_regs(0, 7, 0, 0, 2);
        for (int i = 0; i < 9; i++) push_pixel(16'h0000, i == 0);
        for (int i = 0; i < 9; i++) push_pixel(16'hFFFF, 1'b0);
        for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 16'hFFFF : 16'h0000, i == 0);
        drain();

        // Radius beyond the maximum and the largest gain and height.
        set_regs(15, 7, 4095, 17, 2047);
        for (int i = 0; i < 17 * 17; i++) push_pixel(16'($urandom), i == 0);
        drain();

        // Widest frame with every width bit set; only first-row pixels.
        set_regs(1, 0, 2048, 2047, 3);
        for (int i = 0; i < 40; i++) push_pixel(16'($urandom), i == 0);
        drain();

        // Random phases of mostly well-formed frames with small sizes.
        while (pixel_q.size() + pix_taken < 1950) begin
            r = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(1, 4);
            g = $urandom_range(0, 7);
            case ($urandom_range(0, 3))
                0: k = $urandom_range(0, 4095);
                1: k = 0;
                default: k = $urandom_range(256, 1024);
            endcase
            w = 2 * r + 1 + ((r == 8) ? $urandom_range(0, 2) : $urandom_range(0, 6));
            h = 2 * r + 1 + ((r == 8) ? 0 : $urandom_range(0, 5));
            style = $urandom_range(0, 2);
            base = $urandom_range(0, 65000);
            set_regs(r, g, k, w, h);
            cnt = w * h * ((r == 8) ? 1 : $urandom_range(1, 2));
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cnt - 1) : -1;
            for (int i = 0; i < cnt; i++) begin
                // Now and then a frame restarts part-way through.
                push_pixel(make_pixel(style, base), i == 0 || i == cut);
            end
            drain();
        end

        if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
